[src/mqs_pkg.sv]
package mqs_pkg;
	localparam int MaxItems = 64;
	localparam int IdxW = $clog2(MaxItems);
	localparam int CntW = IdxW + 1;
	localparam int StackDepth = 64;
	localparam int SpW = $clog2(StackDepth);
	localparam logic [31:0] SignBias = 32'h8000_0000;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_POP, ST_POP_W,
		ST_MED_A, ST_MED_M, ST_MED_Z, ST_MED_D, ST_MED_SW,
		ST_PIV, ST_PIV_W,
		ST_SCAN_I, ST_SCAN_I_W,
		ST_SCAN_J, ST_SCAN_J_W,
		ST_SWAP,
		ST_FIN, ST_PUSH1, ST_PUSH2,
		ST_OUT, ST_OUT_W
	} state_t;
endpackage

[src/median_of_three_quicksort.sv]
// Loading accepts one beat per cycle while busy is low; busy is high while the set is sorted and emitted.
// Each pending range popped from the stack is partitioned in place; a range above three elements
// first moves the median of three to its top as the pivot. Sorting ends when the stack is found
// empty.
// A one-element set goes straight to output. Results are then emitted one at a time, and
// the receiver cannot stall. Reset (arst_n low, asynchronous) clears the controller.
module median_of_three_quicksort import mqs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	input  logic               is_final,
	output logic               strobe,
	output logic signed [31:0] sorted_value,
	output logic               end_of_run
);
	logic [31:0] mem [MaxItems];
	logic [2*IdxW-1:0] stk [StackDepth];
	logic [31:0] rd_q;
	logic [2*IdxW-1:0] srd_q;

	state_t state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic [SpW:0] sp_q;
	logic [IdxW-1:0] lo_q, hi_q, i_q, addr;
	logic signed [IdxW+1:0] j_q;
	logic [31:0] a_q, m_q, z_q, piv_q, t_q;
	logic [IdxW-1:0] pick_q;
	logic [IdxW-1:0] mid;
	logic [IdxW:0] midsum;
	logic we;
	logic [31:0] wd;
	logic swap_phase_q;
	logic [IdxW-1:0] p_q;
	logic pend2_q;
	logic [2*IdxW-1:0] push2_q;
	logic [IdxW-1:0] ok_q;
	logic out_last;
	logic load_last;
	logic i_ge_j;
	logic left_big, push_lo, push_hi;
	logic s_we;
	logic [SpW-1:0] s_waddr, s_raddr;
	logic [2*IdxW-1:0] s_wd;
	logic [IdxW-1:0] pop_lo, pop_hi;

	assign midsum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = midsum[IdxW:1];
	assign busy = (state_q != ST_LOAD);
	assign load_last = start && (is_final || cnt_q == CntW'(MaxItems - 1));
	assign out_last = (i_q == ok_q);
	assign i_ge_j = ($signed({2'b00, i_q}) >= j_q);
	assign left_big = (p_q - lo_q) > (hi_q - p_q);
	assign push_lo = p_q > lo_q + 1'b1;
	assign push_hi = ({1'b0, p_q} + 1'b1) < {1'b0, hi_q};
	assign pop_lo = srd_q[2*IdxW-1:IdxW];
	assign pop_hi = srd_q[IdxW-1:0];
	assign s_raddr = sp_q[SpW-1:0] - 1'b1;

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (s_we) stk[s_waddr] <= s_wd;
		srd_q <= stk[s_raddr];
	end

	// Memory port control: address and write are decided per state.
	always_comb begin
		addr = i_q;
		we = 1'b0;
		wd = t_q;
		unique case (state_q)
			ST_LOAD: begin
				addr = cnt_q[IdxW-1:0];
				we = start;
				wd = value ^ SignBias;
			end
			ST_MED_A: addr = lo_q;
			ST_MED_M: addr = mid;
			ST_MED_Z: addr = hi_q;
			ST_MED_D: begin
				addr = hi_q;
			end
			ST_MED_SW: begin
				addr = swap_phase_q ? pick_q : hi_q;
				we = 1'b1;
				wd = swap_phase_q ? z_q : t_q;
			end
			ST_PIV, ST_PIV_W: addr = hi_q;
			ST_SCAN_I, ST_SCAN_I_W: addr = i_q;
			ST_SCAN_J, ST_SCAN_J_W: addr = j_q[IdxW-1:0];
			ST_SWAP: begin
				addr = swap_phase_q ? j_q[IdxW-1:0] : i_q;
				we = 1'b1;
				wd = swap_phase_q ? a_q : z_q;
			end
			ST_FIN: begin
				addr = swap_phase_q ? hi_q : i_q;
				we = 1'b1;
				wd = swap_phase_q ? a_q : piv_q;
			end
			ST_OUT, ST_OUT_W: addr = i_q;
			default: ;
		endcase
	end

	// Range stack port control.
	always_comb begin
		s_we = 1'b0;
		s_waddr = sp_q[SpW-1:0];
		s_wd = push2_q;
		unique case (state_q)
			ST_LOAD: begin
				s_we = load_last && (cnt_q != '0);
				s_waddr = '0;
				s_wd = {IdxW'(0), cnt_q[IdxW-1:0]};
			end
			ST_PUSH1: begin
				s_we = left_big ? push_lo : push_hi;
				s_wd = left_big ? {lo_q, p_q - 1'b1} : {p_q + 1'b1, hi_q};
			end
			ST_PUSH2: s_we = pend2_q;
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (load_last)
				state_d = (cnt_q == '0) ? ST_OUT : ST_POP;
			ST_POP: state_d = (sp_q == '0) ? ST_OUT : ST_POP_W;
			ST_POP_W: begin
				if (pop_lo >= pop_hi) state_d = ST_POP;
				else if (pop_hi - pop_lo > IdxW'(2)) state_d = ST_MED_A;
				else state_d = ST_PIV;
			end
			ST_MED_A: state_d = ST_MED_M;
			ST_MED_M: state_d = ST_MED_Z;
			ST_MED_Z: state_d = ST_MED_D;
			ST_MED_D: state_d = ST_MED_SW;
			ST_MED_SW: state_d = swap_phase_q ? ST_PIV : ST_MED_SW;
			ST_PIV: state_d = ST_PIV_W;
			ST_PIV_W: state_d = ST_SCAN_I;
			ST_SCAN_I: state_d = (i_q < hi_q) ? ST_SCAN_I_W : ST_SCAN_J;
			ST_SCAN_I_W: state_d = (rd_q < piv_q) ? ST_SCAN_I : ST_SCAN_J;
			ST_SCAN_J: begin
				if (j_q >= $signed({2'b00, lo_q})) state_d = ST_SCAN_J_W;
				else state_d = i_ge_j ? ST_FIN : ST_SWAP;
			end
			ST_SCAN_J_W: begin
				if (rd_q > piv_q) state_d = ST_SCAN_J;
				else state_d = i_ge_j ? ST_FIN : ST_SWAP;
			end
			ST_SWAP: state_d = swap_phase_q ? ST_SCAN_I : ST_SWAP;
			ST_FIN: state_d = swap_phase_q ? ST_PUSH1 : ST_FIN;
			ST_PUSH1: state_d = ST_PUSH2;
			ST_PUSH2: state_d = ST_POP;
			ST_OUT: state_d = ST_OUT_W;
			ST_OUT_W: state_d = out_last ? ST_LOAD : ST_OUT;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			sp_q <= '0;
			strobe <= 1'b0;
			end_of_run <= 1'b0;
			swap_phase_q <= 1'b0;
			pend2_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe <= (state_q == ST_OUT_W);
			end_of_run <= (state_q == ST_OUT_W) && out_last;
			// An exchange is split into two phases of the memory port; the phase is clear on entry.
			swap_phase_q <= (state_q == ST_MED_SW || state_q == ST_SWAP || state_q == ST_FIN)
				? ~swap_phase_q : 1'b0;
			if (state_q == ST_LOAD && start) cnt_q <= load_last ? '0 : cnt_q + 1'b1;
			if (state_q == ST_PUSH1) pend2_q <= left_big ? push_hi : push_lo;
			if (state_q == ST_POP_W) sp_q <= sp_q - 1'b1;
			else if (s_we) sp_q <= (state_q == ST_LOAD) ? (SpW+1)'(1) : sp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: if (load_last) begin
				ok_q <= cnt_q[IdxW-1:0];
				i_q <= '0;
			end
			ST_POP: if (sp_q == '0) i_q <= '0;
			ST_POP_W: begin
				lo_q <= pop_lo;
				hi_q <= pop_hi;
			end
			ST_MED_M: a_q <= rd_q;
			ST_MED_Z: m_q <= rd_q;
			ST_MED_D: begin
				z_q <= rd_q;
				if (a_q > rd_q) begin
					if (rd_q > m_q) begin
						pick_q <= hi_q; t_q <= rd_q;
					end else if (a_q > m_q) begin
						pick_q <= mid; t_q <= m_q;
					end else begin
						pick_q <= lo_q; t_q <= a_q;
					end
				end else if (m_q < a_q) begin
					pick_q <= lo_q; t_q <= a_q;
				end else if (rd_q > m_q) begin
					pick_q <= mid; t_q <= m_q;
				end else begin
					pick_q <= hi_q; t_q <= rd_q;
				end
			end
			ST_PIV_W: begin
				piv_q <= rd_q;
				i_q <= lo_q;
				j_q <= {2'b00, hi_q} - 1'b1;
			end
			ST_SCAN_I_W: begin
				if (rd_q < piv_q) i_q <= i_q + 1'b1;
				else a_q <= rd_q;
			end
			ST_SCAN_J_W: begin
				if (rd_q > piv_q) j_q <= j_q - 1'b1;
				else z_q <= rd_q;
			end
			ST_SWAP: if (swap_phase_q) begin
				i_q <= i_q + 1'b1;
				j_q <= j_q - 1'b1;
			end
			ST_FIN: begin
				// a_q holds the element at i when the scan stopped on it.
				if (!swap_phase_q && i_q == hi_q) a_q <= piv_q;
				if (swap_phase_q) p_q <= i_q;
			end
			ST_PUSH1: push2_q <= left_big ? {p_q + 1'b1, hi_q} : {lo_q, p_q - 1'b1};
			ST_OUT_W: begin
				sorted_value <= rd_q ^ SignBias;
				i_q <= i_q + 1'b1;
			end
			default: ;
		endcase
	end
endmodule
